// ===== rtl/bpfa_pkg.sv =====
// Shared types, constants and helpers for the page frame allocator.
`default_nettype none
package bpfa_pkg;

  localparam int NumPages  = 32768;
  localparam int PageBytes = 4096;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_ADD   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_READ,
    ST_MODIFY,
    ST_RESP
  } back_state_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic        ok;
    logic        page_used;
    logic [15:0] pages_free;
    logic [15:0] pages_used;
    logic [15:0] used_peak;
    logic [15:0] pages_managed;
    logic [31:0] alloc_total;
    logic [31:0] free_total;
  } result_t;

  // index of the lowest set bit, zero when none
  function automatic logic [4:0] lowest_set32(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/bpfa_fifo.sv =====
// Small queue used between the request front end, the back end and the result port.
`default_nettype none
module bpfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

endmodule
`default_nettype wire

// ===== rtl/bpfa_front.sv =====
// Request front end: registers a request, derives page index and range check.
`default_nettype none
module bpfa_front #(
  parameter int NUM_PAGES  = bpfa_pkg::NumPages,
  parameter int PAGE_BYTES = bpfa_pkg::PageBytes,
  parameter int PB         = 15
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    action,
  input  wire logic [31:0]   address,
  input  wire logic          clearing,
  output logic               q_push,
  input  wire logic          q_full,
  output logic [PB+2:0]      q_data
);

  localparam int PS = $clog2(PAGE_BYTES);

  logic          stage_valid;
  logic [1:0]    stage_action;
  logic          stage_in_range;
  logic [PB-1:0] stage_page;
  logic [31:0]   page_full;
  logic          accept;

  assign page_full = address >> PS;
  assign full      = clearing || (stage_valid && q_full);
  assign accept    = push && !full;
  assign q_push    = stage_valid && !q_full;
  assign q_data    = {stage_action, stage_in_range, stage_page};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_action   <= action;
      stage_in_range <= page_full < 32'(NUM_PAGES);
      stage_page     <= page_full[PB-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bpfa_back.sv =====
// Back end: used-bit map in RAM with word and group summaries, counters, sequencer.
`default_nettype none
module bpfa_back #(
  parameter int PAGE_BYTES = bpfa_pkg::PageBytes,
  parameter int GROUPS     = 32,
  parameter int GA         = 5,
  parameter int PB         = 15
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_empty,
  input  wire logic [PB+2:0]      cmd_data,
  output logic                    cmd_pop,
  input  wire logic               res_full,
  output logic                    res_push,
  output bpfa_pkg::result_t       res_data,
  output logic                    clearing
);

  localparam int PS    = $clog2(PAGE_BYTES);
  localparam int WX    = GA + 5;
  localparam int DEPTH = GROUPS * 32;

  bpfa_pkg::back_state_t state, state_next;

  logic [WX-1:0]     clr_addr;
  logic [31:0]       wsum [GROUPS];
  logic [GROUPS-1:0] gsum;

  bpfa_pkg::action_t act;
  logic [PB-1:0]     page;
  logic [GA-1:0]     grp_sel;
  logic              grp_any;

  logic [31:0] page_address;
  logic        ok;
  logic        page_used;
  logic [15:0] free_cnt;
  logic [15:0] used_count;
  logic [15:0] peak_count;
  logic [15:0] managed_count;
  logic [31:0] alloc_events;
  logic [31:0] free_events;

  bpfa_pkg::action_t cmd_act;
  logic              cmd_in_range;
  logic [PB-1:0]     cmd_page;

  logic          ram_we;
  logic [WX-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic [GA-1:0] grp_low;
  logic [4:0]    bit_sel;
  logic          old_bit;
  logic [31:0]   new_word;
  logic          change;
  logic [31:0]   row_new;
  logic [15:0]   used_inc;
  logic [63:0]   alloc_byte;

  assign cmd_act      = bpfa_pkg::action_t'(cmd_data[PB+2:PB+1]);
  assign cmd_in_range = cmd_data[PB];
  assign cmd_page     = cmd_data[PB-1:0];
  assign clearing     = (state == bpfa_pkg::ST_CLEAR);

  bpfa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(page[PB-1:5]),
    .rdata(ram_rdata)
  );

  always_comb begin
    grp_low = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (gsum[g]) grp_low = GA'(g);
    end
  end

  always_comb begin
    bit_sel  = (act == bpfa_pkg::ACT_ALLOC) ? bpfa_pkg::lowest_set32(~ram_rdata) : page[4:0];
    old_bit  = ram_rdata[bit_sel];
    new_word = ram_rdata;
    change   = 1'b0;
    case (act)
      bpfa_pkg::ACT_ALLOC: begin
        new_word[bit_sel] = 1'b1;
        change = 1'b1;
      end
      bpfa_pkg::ACT_FREE, bpfa_pkg::ACT_ADD: begin
        new_word[bit_sel] = 1'b0;
        change = old_bit;
      end
      default: change = 1'b0;
    endcase
    row_new             = wsum[page[PB-1:10]];
    row_new[page[9:5]]  = ~&new_word;
    used_inc            = used_count + 16'd1;
    alloc_byte          = 64'({page[PB-1:5], bit_sel}) << PS;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bpfa_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = page[PB-1:5];
    ram_wdata  = new_word;
    case (state)
      bpfa_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '1;
        if (clr_addr == WX'(DEPTH - 1)) state_next = bpfa_pkg::ST_IDLE;
      end
      bpfa_pkg::ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd_act == bpfa_pkg::ACT_ALLOC) state_next = bpfa_pkg::ST_FIND;
          else if (cmd_in_range)              state_next = bpfa_pkg::ST_READ;
          else                                state_next = bpfa_pkg::ST_RESP;
        end
      end
      bpfa_pkg::ST_FIND: state_next = grp_any ? bpfa_pkg::ST_READ : bpfa_pkg::ST_RESP;
      bpfa_pkg::ST_READ: state_next = bpfa_pkg::ST_MODIFY;
      bpfa_pkg::ST_MODIFY: begin
        ram_we     = change;
        state_next = bpfa_pkg::ST_RESP;
      end
      bpfa_pkg::ST_RESP: begin
        res_push   = 1'b1;
        state_next = bpfa_pkg::ST_IDLE;
      end
      default: state_next = bpfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      gsum          <= '0;
      free_cnt      <= '0;
      used_count    <= '0;
      peak_count    <= '0;
      managed_count <= '0;
      alloc_events  <= '0;
      free_events   <= '0;
      for (int g = 0; g < GROUPS; g++) wsum[g] <= '0;
    end else begin
      case (state)
        bpfa_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        bpfa_pkg::ST_MODIFY: begin
          if (change) begin
            wsum[page[PB-1:10]] <= row_new;
            gsum[page[PB-1:10]] <= |row_new;
            case (act)
              bpfa_pkg::ACT_ALLOC: begin
                used_count   <= used_inc;
                free_cnt     <= free_cnt - 16'd1;
                alloc_events <= alloc_events + 32'd1;
                if (used_inc > peak_count) peak_count <= used_inc;
              end
              bpfa_pkg::ACT_FREE: begin
                if (used_count != 16'd0) used_count <= used_count - 16'd1;
                free_cnt    <= free_cnt + 16'd1;
                free_events <= free_events + 32'd1;
              end
              bpfa_pkg::ACT_ADD: begin
                free_cnt      <= free_cnt + 16'd1;
                managed_count <= managed_count + 16'd1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // per-request payload
  always_ff @(posedge clk) begin
    case (state)
      bpfa_pkg::ST_IDLE: begin
        act          <= cmd_act;
        page         <= cmd_page;
        grp_sel      <= grp_low;
        grp_any      <= |gsum;
        page_address <= '0;
        ok           <= 1'b0;
        page_used    <= (cmd_act != bpfa_pkg::ACT_ALLOC);
      end
      bpfa_pkg::ST_FIND: begin
        page <= PB'({grp_sel, bpfa_pkg::lowest_set32(wsum[grp_sel]), 5'd0});
      end
      bpfa_pkg::ST_MODIFY: begin
        ok <= change;
        case (act)
          bpfa_pkg::ACT_ALLOC: begin
            page_address <= alloc_byte[31:0];
            page_used    <= 1'b1;
          end
          bpfa_pkg::ACT_QUERY: page_used <= old_bit;
          default:             page_used <= 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data.page_address  = page_address;
    res_data.ok            = ok;
    res_data.page_used     = page_used;
    res_data.pages_free    = free_cnt;
    res_data.pages_used    = used_count;
    res_data.used_peak     = peak_count;
    res_data.pages_managed = managed_count;
    res_data.alloc_total   = alloc_events;
    res_data.free_total    = free_events;
  end

endmodule
`default_nettype wire

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Flow: an accepted request is registered in the front end and queued; the back end
// takes one request at a time, reads its map word, modifies it and writes it back
// when a bit changes (alloc first finds a word with a free page; a failed alloc, or
// an out-of-range free, query or add, goes straight to its result).
// Reset: synchronous; the map RAM is then set to all ones by a clearing pass of one
// word a cycle, full high meanwhile; counters go to zero.
`default_nettype none
module bitmap_page_frame_allocator #(
  parameter int NUM_PAGES  = bpfa_pkg::NumPages,
  parameter int PAGE_BYTES = bpfa_pkg::PageBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] address,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      page_address,
  output logic             ok,
  output logic             page_used,
  output logic [15:0]      pages_free,
  output logic [15:0]      pages_used,
  output logic [15:0]      used_peak,
  output logic [15:0]      pages_managed,
  output logic [31:0]      alloc_total,
  output logic [31:0]      free_total
);

  localparam int WORDS  = (NUM_PAGES + 31) / 32;
  localparam int GROUPS = (WORDS + 31) / 32;
  localparam int GA     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PB     = GA + 10;

  logic              clearing;
  logic              q_push;
  logic              q_full;
  logic [PB+2:0]     q_wdata;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [PB+2:0]     cmd_data;
  logic              res_push;
  logic              res_full;
  bpfa_pkg::result_t res_wdata;
  bpfa_pkg::result_t res_rdata;

  bpfa_front #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES), .PB(PB)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .action  (action),
    .address (address),
    .clearing(clearing),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  bpfa_fifo #(.WIDTH(PB + 3), .DEPTH(2)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .full (q_full),
    .wdata(q_wdata),
    .pop  (cmd_pop),
    .empty(cmd_empty),
    .rdata(cmd_data)
  );

  bpfa_back #(
    .PAGE_BYTES(PAGE_BYTES), .GROUPS(GROUPS), .GA(GA), .PB(PB)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_data (cmd_data),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata),
    .clearing (clearing)
  );

  bpfa_fifo #(.WIDTH($bits(bpfa_pkg::result_t)), .DEPTH(2)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .wdata(res_wdata),
    .pop  (pop),
    .empty(empty),
    .rdata(res_rdata)
  );

  assign page_address  = res_rdata.page_address;
  assign ok            = res_rdata.ok;
  assign page_used     = res_rdata.page_used;
  assign pages_free    = res_rdata.pages_free;
  assign pages_used    = res_rdata.pages_used;
  assign used_peak     = res_rdata.used_peak;
  assign pages_managed = res_rdata.pages_managed;
  assign alloc_total   = res_rdata.alloc_total;
  assign free_total    = res_rdata.free_total;

  a_res_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into full queue");
  a_clear_blocks: assert property (@(posedge clk) rst |=> full)
    else $error("request taken during map clearing");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !cmd_empty)
    else $error("back end popped empty request queue");

endmodule
`default_nettype wire
